// File: rtl/rau_pkg.sv
// Package for the rational arithmetic unit: action and error codes, widths,
// controller state type and controller/datapath command and status structs.
// No dependencies.
`default_nettype none
package rau_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned ResDenW = 31;
  localparam int unsigned DefWidth = 32;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0, ACT_SUB = 3'd1, ACT_MUL = 3'd2,
    ACT_DIV = 3'd3, ACT_EQ  = 3'd4, ACT_GT  = 3'd5,
    ACT_NOP6 = 3'd6, ACT_NOP7 = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    ERR_OK = 2'd0, ERR_ZDEN = 2'd1, ERR_DIVZ = 2'd2, ERR_OVF = 2'd3
  } error_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_MUL, ST_COMB, ST_GCD_START, ST_GCD, ST_DIVN_START,
    ST_DIVN, ST_DIVD_START, ST_DIVD, ST_FINISH, ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic comb;
    logic div_start;
    logic div_step;
    logic [1:0] div_sel;   // 0 gcd remainder, 1 num/g, 2 den/g
    logic gcd_swap;
    logic take_q_num;
    logic take_q_den;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic early;       // result already settled (error, compare, nop)
    logic gcd_done;    // y == 0
    logic div_done;
  } dp_stat_t;
endpackage
`default_nettype wire

// File: rtl/rau_if.sv
// Valid/ready request channel interface.
// Depends on nothing; payload type given as parameter.
`default_nettype none
interface rau_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/rau_ctrl.sv
// Controller FSM for the rational arithmetic unit.
// Depends on rau_pkg.
`default_nettype none
module rau_ctrl import rau_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  dp_stat_t       stat_i,
  output ctrl_cmd_t      cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.mul = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.comb = 1'b1;
        state_d = ST_COMB;
      end
      ST_COMB: begin
        if (stat_i.early) state_d = ST_OUT;
        else state_d = ST_GCD_START;
      end
      ST_GCD_START: begin
        if (stat_i.gcd_done) state_d = ST_DIVN_START;
        else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel = 2'd0;
          state_d = ST_GCD;
        end
      end
      ST_GCD: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_sel = 2'd0;
        if (stat_i.div_done) begin
          cmd_o.gcd_swap = 1'b1;
          state_d = ST_GCD_START;
        end
      end
      ST_DIVN_START: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel = 2'd1;
        state_d = ST_DIVN;
      end
      ST_DIVN: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_sel = 2'd1;
        if (stat_i.div_done) begin
          cmd_o.take_q_num = 1'b1;
          state_d = ST_DIVD_START;
        end
      end
      ST_DIVD_START: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel = 2'd2;
        state_d = ST_DIVD;
      end
      ST_DIVD: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_sel = 2'd2;
        if (stat_i.div_done) begin
          cmd_o.take_q_den = 1'b1;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  ap_no_in_when_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("accept while result pending");
  ap_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  ap_load_goes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_LOAD) else $error("load lost");
endmodule
`default_nettype wire

// File: rtl/rau_dp.sv
// Datapath: operand normalisation, cross products, sum, GCD and exact
// divisions on a shared radix-2 restoring divider. Depends on rau_pkg.
`default_nettype none
module rau_dp import rau_pkg::*; #(
  parameter int unsigned WIDTH = DefWidth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  ctrl_cmd_t               cmd_i,
  output dp_stat_t                stat_o,
  input  wire logic [2:0]         action_i,
  input  wire logic [DataW-1:0]   a_num_i,
  input  wire logic [DataW-1:0]   a_den_i,
  input  wire logic [DataW-1:0]   b_num_i,
  input  wire logic [DataW-1:0]   b_den_i,
  output logic [DataW-1:0]        res_num_o,
  output logic [ResDenW-1:0]      res_den_o,
  output logic                    is_true_o,
  output error_e                  error_o
);
  localparam int unsigned MW = WIDTH + 1;      // normalised magnitude
  localparam int unsigned PW = 2 * WIDTH;      // product magnitude
  localparam int unsigned SW = PW + 1;         // sum magnitude
  localparam int unsigned CW = $clog2(SW + 1);

  action_e act_q;
  logic [MW-1:0] anm_q, adm_q, bnm_q, bdm_q;
  logic an_s_q, bn_s_q;
  logic zden_q;
  logic [PW-1:0] p1_q, p2_q, pd_q;
  logic [SW-1:0] x_q, y_q, nm_q, dm_q;
  logic neg_q, early_q;
  logic [SW-1:0] rem_q, quo_q, dvs_q;
  logic [CW-1:0] cnt_q;

  logic signed [WIDTH-1:0] an_w, ad_w, bn_w, bd_w;
  assign an_w = a_num_i[WIDTH-1:0];
  assign ad_w = a_den_i[WIDTH-1:0];
  assign bn_w = b_num_i[WIDTH-1:0];
  assign bd_w = b_den_i[WIDTH-1:0];

  function automatic logic [MW-1:0] magf(input logic signed [WIDTH-1:0] v);
    logic [MW-1:0] e;
    e = {v[WIDTH-1], v};
    return v[WIDTH-1] ? (~e + 1'b1) : e;
  endfunction

  // load: sign-normalise so denominators are positive
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_e'(action_i);
      zden_q <= (ad_w == '0) || (bd_w == '0);
      anm_q  <= magf(an_w);
      adm_q  <= magf(ad_w);
      bnm_q  <= magf(bn_w);
      bdm_q  <= magf(bd_w);
      an_s_q <= (an_w != '0) && (an_w[WIDTH-1] ^ ad_w[WIDTH-1]);
      bn_s_q <= (bn_w != '0) && (bn_w[WIDTH-1] ^ bd_w[WIDTH-1]);
    end
  end

  // products; magnitudes at most 2^(WIDTH-1) so each fits PW bits
  logic [MW-1:0] m1a, m1b, m2a, m2b;
  always_comb begin
    m1a = anm_q; m1b = bdm_q;
    m2a = bnm_q; m2b = adm_q;
    if (act_q == ACT_MUL) begin
      m1b = bnm_q; m2a = anm_q; m2b = bdm_q;
    end else if (act_q == ACT_DIV) begin
      m2a = adm_q; m2b = bnm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      p1_q <= PW'(m1a) * PW'(m1b);
      p2_q <= PW'(m2a) * PW'(m2b);
      pd_q <= PW'(adm_q) * PW'(bdm_q);
    end
  end

  // combine: signed sum, compare, early-out decisions
  logic bs_eff;
  logic [SW-1:0] s_mag;
  logic s_neg;
  logic cmp_t;
  logic ls, rs;
  always_comb begin
    bs_eff = bn_s_q;
    if (act_q == ACT_SUB) bs_eff = (bnm_q != '0) ? ~bn_s_q : bn_s_q;
    if (an_s_q == bs_eff) begin
      s_mag = {1'b0, p1_q} + {1'b0, p2_q};
      s_neg = an_s_q;
    end else if (p1_q >= p2_q) begin
      s_mag = {1'b0, p1_q - p2_q};
      s_neg = an_s_q;
    end else begin
      s_mag = {1'b0, p2_q - p1_q};
      s_neg = bs_eff;
    end
    ls = an_s_q && (p1_q != '0);
    rs = bn_s_q && (p2_q != '0);
    if (act_q == ACT_EQ) cmp_t = (ls == rs) && (p1_q == p2_q);
    else if (ls != rs) cmp_t = rs;
    else cmp_t = ls ? (p1_q < p2_q) : (p1_q > p2_q);
  end

  // shared restoring divider: rem_q/quo_q over SW steps
  logic [SW-1:0] dv_a, dv_b;
  always_comb begin
    unique case (cmd_i.div_sel)
      2'd0:    begin dv_a = x_q;  dv_b = y_q; end
      2'd1:    begin dv_a = nm_q; dv_b = x_q; end
      default: begin dv_a = dm_q; dv_b = x_q; end
    endcase
  end

  logic [SW:0] trial;
  assign trial = {rem_q, quo_q[SW-1]} - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else if (cmd_i.div_start) cnt_q <= CW'(SW);
    else if (cmd_i.div_step && cnt_q != '0) cnt_q <= cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= dv_a;
      dvs_q <= dv_b;
    end else if (cmd_i.div_step && cnt_q != '0) begin
      if (!trial[SW]) begin
        rem_q <= trial[SW-1:0];
        quo_q <= {quo_q[SW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[SW-2:0], quo_q[SW-1]};
        quo_q <= {quo_q[SW-2:0], 1'b0};
      end
    end
  end

  assign stat_o.div_done = (cnt_q == '0) && cmd_i.div_step;
  assign stat_o.gcd_done = (y_q == '0);
  assign stat_o.early = early_q;

  logic [SW-1:0] lim;
  assign lim = SW'(1) << (WIDTH - 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.comb) begin
      early_q <= 1'b1;
      res_num_o <= '0;
      res_den_o <= ResDenW'(1);
      is_true_o <= 1'b0;
      error_o <= ERR_OK;
      nm_q <= s_mag;
      dm_q <= {1'b0, pd_q};
      neg_q <= s_neg;
      if (zden_q) error_o <= ERR_ZDEN;
      else if (act_q == ACT_EQ || act_q == ACT_GT) is_true_o <= cmp_t;
      else if (act_q == ACT_DIV && bnm_q == '0) error_o <= ERR_DIVZ;
      else if (act_q == ACT_ADD || act_q == ACT_SUB) begin
        early_q <= 1'b0;
        x_q <= s_mag;
        y_q <= {1'b0, pd_q};
        if (s_mag == '0) neg_q <= 1'b0;
      end else if (act_q == ACT_MUL || act_q == ACT_DIV) begin
        early_q <= 1'b0;
        nm_q <= {1'b0, p1_q};
        x_q  <= {1'b0, p1_q};
        dm_q <= {1'b0, p2_q};
        y_q  <= {1'b0, p2_q};
        neg_q <= (an_s_q ^ bn_s_q) && (p1_q != '0);
        if (act_q == ACT_MUL) begin
          dm_q <= {1'b0, pd_q};
          y_q  <= {1'b0, pd_q};
        end
      end
    end else if (cmd_i.gcd_swap) begin
      x_q <= y_q;
      y_q <= rem_q;
    end else if (cmd_i.take_q_num) begin
      nm_q <= quo_q;
    end else if (cmd_i.take_q_den) begin
      dm_q <= quo_q;
    end else if (cmd_i.finish) begin
      if (dm_q > lim - 1'b1 || nm_q > (neg_q ? lim : lim - 1'b1)) begin
        error_o <= ERR_OVF;
      end else begin
        res_num_o <= DataW'($signed(neg_q ? (~nm_q + 1'b1) : nm_q));
        res_den_o <= ResDenW'(dm_q);
      end
    end
  end

  ap_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start && cmd_i.div_sel != 2'd0 |-> x_q != '0)
    else $error("divide by zero gcd");
  ap_cnt_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |=> cnt_q == CW'(SW)) else $error("counter not loaded");
  ap_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> dm_q != '0) else $error("zero reduced denominator");
endmodule
`default_nettype wire

// File: rtl/rational_arithmetic_unit_core.sv
// Rational arithmetic unit top level: one request at a time.
// Errors, compares and unused actions settle early; add, sub, mul and div also run
// k Euclid steps plus two exact divisions, all on one bit-serial divider;
// k stays below about 95 at WIDTH 32.
// A new request is accepted only after the previous result has been taken.
// Reset: rst_ni asynchronous active low returns the controller to idle.
`default_nettype none
module rational_arithmetic_unit_core import rau_pkg::*; #(
  parameter int unsigned WIDTH = DefWidth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rau_if.sink       in_if,
  rau_if.source     out_if
);
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  rau_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rau_dp #(.WIDTH(WIDTH)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i    (cmd),
    .stat_o   (stat),
    .action_i (in_if.data.action),
    .a_num_i  (in_if.data.a_num),
    .a_den_i  (in_if.data.a_den),
    .b_num_i  (in_if.data.b_num),
    .b_den_i  (in_if.data.b_den),
    .res_num_o(out_if.data.res_num),
    .res_den_o(out_if.data.res_den),
    .is_true_o(out_if.data.is_true),
    .error_o  (out_if.data.error)
  );
endmodule
`default_nettype wire
